// File: rtl/core/dlrs_pkg.sv
package dlrs_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int RADIX_BINS = 10;
    localparam int KEY_W      = 31;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int DIGIT_W    = 4;
    localparam int PASS_W     = 4;
    localparam int MAX_DIGITS = 10;
    localparam int ENTRY_W    = 2 * KEY_W;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = KEY_W + 32;
    localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

    // read pipeline operation
    typedef enum logic [1:0] {
        OP_COUNT   = 2'd0,
        OP_SCATTER = 2'd1,
        OP_EMIT    = 2'd2
    } op_t;

    typedef struct packed {
        logic              load;
        logic              latch_digits;
        logic              clear_counts;
        logic              prefix_step;
        logic              rd_en;
        op_t               rd_op;
        logic [ADDR_W-1:0] rd_addr;
        logic              rd_last;
        logic              bank;
        logic              batch_done;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  item_count;
        logic [PASS_W-1:0] passes;
        logic              pipe_busy;
        logic              emit_ready;
        logic              out_valid;
    } stat_t;

    // 10^k for k = 0..9
    function automatic logic [KEY_W-1:0] pow10(input logic [DIGIT_W-1:0] k);
        logic [KEY_W-1:0] p;
        p = KEY_W'(1);
        for (int i = 0; i < MAX_DIGITS - 1; i++)
        begin
            if (DIGIT_W'(i) < k)
            begin
                p = KEY_W'(p * KEY_W'(10));
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/core/dlrs_ctrl.sv
module dlrs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    input  dlrs_pkg::stat_t stat,
    output dlrs_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIGITS,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_EMIT
    } state_t;

    state_t                           state_reg;
    logic [dlrs_pkg::CNT_W-1:0]       idx_reg;
    logic [dlrs_pkg::PASS_W-1:0]      pass_reg;
    logic [dlrs_pkg::DIGIT_W-1:0]     pidx_reg;
    logic                             bank_reg;
    logic                             accept;
    logic                             emit_issue;

    assign in_ready   = (state_reg == ST_LOAD);
    assign accept     = in_valid && in_ready;
    assign emit_issue = (state_reg == ST_EMIT) && (idx_reg != stat.item_count)
                        && stat.emit_ready;

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.bank    = bank_reg;
        cmd.rd_addr = idx_reg[dlrs_pkg::ADDR_W-1:0];
        cmd.rd_op   = dlrs_pkg::OP_COUNT;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load = accept;
            end
            ST_DIGITS:
            begin
                cmd.latch_digits = 1'b1;
            end
            ST_CLEAR:
            begin
                cmd.clear_counts = 1'b1;
            end
            ST_COUNT:
            begin
                cmd.rd_en = (idx_reg != stat.item_count);
                cmd.rd_op = dlrs_pkg::OP_COUNT;
            end
            ST_PREFIX:
            begin
                cmd.prefix_step = 1'b1;
            end
            ST_SCATTER:
            begin
                cmd.rd_en   = (idx_reg != '0);
                cmd.rd_op   = dlrs_pkg::OP_SCATTER;
                cmd.rd_addr = dlrs_pkg::ADDR_W'(idx_reg - dlrs_pkg::CNT_W'(1));
            end
            ST_EMIT:
            begin
                cmd.rd_en      = emit_issue;
                cmd.rd_op      = dlrs_pkg::OP_EMIT;
                cmd.rd_last    = (idx_reg + dlrs_pkg::CNT_W'(1) == stat.item_count);
                cmd.batch_done = (idx_reg == stat.item_count) && !stat.pipe_busy
                                 && !stat.out_valid;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            idx_reg   <= '0;
            pass_reg  <= '0;
            pidx_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept && in_last)
                    begin
                        state_reg <= ST_DIGITS;
                    end
                end
                ST_DIGITS:
                begin
                    pass_reg  <= '0;
                    bank_reg  <= 1'b0;
                    state_reg <= ST_CLEAR;
                end
                ST_CLEAR:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_COUNT;
                end
                ST_COUNT:
                begin
                    if (idx_reg != stat.item_count)
                    begin
                        idx_reg <= idx_reg + dlrs_pkg::CNT_W'(1);
                    end
                    else if (!stat.pipe_busy)
                    begin
                        pidx_reg  <= '0;
                        state_reg <= ST_PREFIX;
                    end
                end
                ST_PREFIX:
                begin
                    pidx_reg <= pidx_reg + dlrs_pkg::DIGIT_W'(1);
                    if (pidx_reg == dlrs_pkg::DIGIT_W'(dlrs_pkg::RADIX_BINS - 1))
                    begin
                        idx_reg   <= stat.item_count;
                        state_reg <= ST_SCATTER;
                    end
                end
                ST_SCATTER:
                begin
                    if (idx_reg != '0)
                    begin
                        idx_reg <= idx_reg - dlrs_pkg::CNT_W'(1);
                    end
                    else if (!stat.pipe_busy)
                    begin
                        pass_reg <= pass_reg + dlrs_pkg::PASS_W'(1);
                        bank_reg <= !bank_reg;
                        idx_reg  <= '0;
                        if (pass_reg + dlrs_pkg::PASS_W'(1) == stat.passes)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_CLEAR;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_issue)
                    begin
                        idx_reg <= idx_reg + dlrs_pkg::CNT_W'(1);
                    end
                    if (cmd.batch_done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/dlrs_datapath.sv
module dlrs_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dlrs_pkg::KEY_W-1:0]   key_in,
    input  dlrs_pkg::cmd_t               cmd,
    output dlrs_pkg::stat_t              stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [dlrs_pkg::KEY_W-1:0]   out_key,
    output logic                         out_last,
    output logic                         out_ovf
);

    // ping-pong key stores, each entry {key, remaining quotient}
    logic [dlrs_pkg::ENTRY_W-1:0] mem_a [dlrs_pkg::MAX_ITEMS];
    logic [dlrs_pkg::ENTRY_W-1:0] mem_b [dlrs_pkg::MAX_ITEMS];
    logic [dlrs_pkg::ENTRY_W-1:0] rd_a_reg;
    logic [dlrs_pkg::ENTRY_W-1:0] rd_b_reg;

    logic [dlrs_pkg::CNT_W-1:0]   cnt_reg [dlrs_pkg::RADIX_BINS];
    logic [dlrs_pkg::CNT_W-1:0]   acc_reg;
    logic [dlrs_pkg::CNT_W-1:0]   prefix_sum;

    logic [dlrs_pkg::CNT_W-1:0]   item_count_reg;
    logic [dlrs_pkg::KEY_W-1:0]   largest_reg;
    logic                         ovf_reg;
    logic [dlrs_pkg::PASS_W-1:0]  passes_reg;
    logic [dlrs_pkg::PASS_W-1:0]  passes_next;

    // read pipeline
    logic                         s1_valid_reg;
    dlrs_pkg::op_t                s1_op_reg;
    logic                         s1_last_reg;
    logic                         s1_bank_reg;
    logic                         s2_valid_reg;
    dlrs_pkg::op_t                s2_op_reg;
    logic                         s2_bank_reg;
    logic [dlrs_pkg::KEY_W-1:0]   s2_key_reg;
    logic [dlrs_pkg::KEY_W-1:0]   s2_quot_reg;
    logic [dlrs_pkg::PROD_W-1:0]  prod_reg;

    logic [dlrs_pkg::ENTRY_W-1:0] s1_entry;
    logic [dlrs_pkg::KEY_W-1:0]   s1_key;
    logic [dlrs_pkg::KEY_W-1:0]   s1_quot;
    logic [dlrs_pkg::QUOT_W-1:0]  q10;
    logic [dlrs_pkg::KEY_W-1:0]   q10_times10;
    logic [dlrs_pkg::KEY_W-1:0]   rem_full;
    logic [dlrs_pkg::DIGIT_W-1:0] digit;
    logic [dlrs_pkg::CNT_W-1:0]   slot;
    logic                         s2_count;
    logic                         s2_scatter;

    logic                         wr_a_en;
    logic [dlrs_pkg::ADDR_W-1:0]  wr_a_addr;
    logic [dlrs_pkg::ENTRY_W-1:0] wr_a_data;
    logic                         wr_b_en;
    logic [dlrs_pkg::ENTRY_W-1:0] scat_data;
    logic                         load_fits;

    logic                         out_valid_reg;
    logic [dlrs_pkg::KEY_W-1:0]   out_key_reg;
    logic                         out_last_reg;
    logic                         out_ovf_reg;

    // stage 1 entry select and stage 2 digit extraction
    assign s1_entry    = s1_bank_reg ? rd_b_reg : rd_a_reg;
    assign s1_key      = s1_entry[dlrs_pkg::ENTRY_W-1:dlrs_pkg::KEY_W];
    assign s1_quot     = s1_entry[dlrs_pkg::KEY_W-1:0];
    assign q10         = prod_reg[dlrs_pkg::PROD_W-1:dlrs_pkg::RECIP_SHIFT];
    assign q10_times10 = dlrs_pkg::KEY_W'({q10, 3'b000}) + dlrs_pkg::KEY_W'({q10, 1'b0});
    assign rem_full    = s2_quot_reg - q10_times10;
    assign digit       = rem_full[dlrs_pkg::DIGIT_W-1:0];
    assign s2_count    = s2_valid_reg && (s2_op_reg == dlrs_pkg::OP_COUNT);
    assign s2_scatter  = s2_valid_reg && (s2_op_reg == dlrs_pkg::OP_SCATTER);
    assign slot        = cnt_reg[digit] - dlrs_pkg::CNT_W'(1);
    assign scat_data   = {s2_key_reg, dlrs_pkg::KEY_W'(q10)};
    assign prefix_sum  = cnt_reg[0] + acc_reg;
    assign load_fits   = (item_count_reg < dlrs_pkg::CNT_W'(dlrs_pkg::MAX_ITEMS));

    // store write ports: load fills A, scatter writes the opposite bank
    always_comb
    begin
        wr_a_en   = 1'b0;
        wr_a_addr = slot[dlrs_pkg::ADDR_W-1:0];
        wr_a_data = scat_data;
        if (cmd.load && load_fits)
        begin
            wr_a_en   = 1'b1;
            wr_a_addr = item_count_reg[dlrs_pkg::ADDR_W-1:0];
            wr_a_data = {key_in, key_in};
        end
        else if (s2_scatter && s2_bank_reg)
        begin
            wr_a_en = 1'b1;
        end
    end
    assign wr_b_en = s2_scatter && !s2_bank_reg;

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
        begin
            mem_a[wr_a_addr] <= wr_a_data;
        end
        rd_a_reg <= mem_a[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
        begin
            mem_b[slot[dlrs_pkg::ADDR_W-1:0]] <= scat_data;
        end
        rd_b_reg <= mem_b[cmd.rd_addr];
    end

    // digit count of the largest key, at least one
    always_comb
    begin
        passes_next = dlrs_pkg::PASS_W'(1);
        for (int k = 1; k < dlrs_pkg::MAX_DIGITS; k++)
        begin
            if (largest_reg >= dlrs_pkg::pow10(dlrs_pkg::DIGIT_W'(k)))
            begin
                passes_next = passes_next + dlrs_pkg::PASS_W'(1);
            end
        end
    end

    // batch bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= '0;
            largest_reg    <= '0;
            ovf_reg        <= 1'b0;
            passes_reg     <= dlrs_pkg::PASS_W'(1);
        end
        else
        begin
            if (cmd.batch_done)
            begin
                item_count_reg <= '0;
                largest_reg    <= '0;
                ovf_reg        <= 1'b0;
            end
            else if (cmd.load)
            begin
                if (load_fits)
                begin
                    item_count_reg <= item_count_reg + dlrs_pkg::CNT_W'(1);
                    if (key_in > largest_reg)
                    begin
                        largest_reg <= key_in;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.latch_digits)
            begin
                passes_reg <= passes_next;
            end
        end
    end

    // bin counters: clear, histogram, rotating prefix sum, scatter slots
    always_ff @(posedge clk)
    begin
        if (cmd.clear_counts)
        begin
            for (int b = 0; b < dlrs_pkg::RADIX_BINS; b++)
            begin
                cnt_reg[b] <= '0;
            end
            acc_reg <= '0;
        end
        else if (cmd.prefix_step)
        begin
            for (int b = 0; b < dlrs_pkg::RADIX_BINS - 1; b++)
            begin
                cnt_reg[b] <= cnt_reg[b+1];
            end
            cnt_reg[dlrs_pkg::RADIX_BINS-1] <= prefix_sum;
            acc_reg <= prefix_sum;
        end
        else if (s2_count)
        begin
            cnt_reg[digit] <= cnt_reg[digit] + dlrs_pkg::CNT_W'(1);
        end
        else if (s2_scatter)
        begin
            cnt_reg[digit] <= slot;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg && (s1_op_reg != dlrs_pkg::OP_EMIT);
            if (s1_valid_reg && (s1_op_reg == dlrs_pkg::OP_EMIT))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= cmd.rd_op;
        s1_last_reg <= cmd.rd_last;
        s1_bank_reg <= cmd.bank;
        s2_op_reg   <= s1_op_reg;
        s2_bank_reg <= s1_bank_reg;
        s2_key_reg  <= s1_key;
        s2_quot_reg <= s1_quot;
        prod_reg    <= dlrs_pkg::PROD_W'(s1_quot) * dlrs_pkg::PROD_W'(dlrs_pkg::RECIP_10);
        if (s1_valid_reg && (s1_op_reg == dlrs_pkg::OP_EMIT))
        begin
            out_key_reg  <= s1_key;
            out_last_reg <= s1_last_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

    assign stat.item_count = item_count_reg;
    assign stat.passes     = passes_reg;
    assign stat.pipe_busy  = s1_valid_reg || s2_valid_reg;
    assign stat.emit_ready = !(s1_valid_reg && (s1_op_reg == dlrs_pkg::OP_EMIT))
                             && (!out_valid_reg || out_ready);
    assign stat.out_valid  = out_valid_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= dlrs_pkg::CNT_W'(dlrs_pkg::MAX_ITEMS))
        else $error("item count beyond capacity");

    a_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_scatter |-> (cnt_reg[digit] != '0))
        else $error("scatter bin underflow");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == dlrs_pkg::OP_EMIT)) |-> !out_valid_reg)
        else $error("emit word overwrites pending output");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (digit < dlrs_pkg::DIGIT_W'(dlrs_pkg::RADIX_BINS)))
        else $error("digit out of range");
`endif

endmodule

// File: rtl/core/decimal_lsd_radix_sort.sv
// Channel  Dir  Bus                 Fields (low bit up)
// s_axis   in   tdata[31:0]         key_in[30:0], zero pad
//               tlast               batch_end
// m_axis   out  tdata[31:0]         sorted_key[30:0], zero pad
//               tlast               run_end
//               tuser               overflowed
//
// Keys load one per cycle. After the last key, the digit count is latched,
// then each decimal digit pass runs through clear, histogram read,
// 10-step prefix and scatter read, each read followed by a
// read/multiply pipeline drain. Each sorted word is read only once the
// previous one has left the store read and the output is free or being taken.
// Input is stalled from batch end until the last sorted word is taken.
// Reset clears control only; key stores need no clearing.
module decimal_lsd_radix_sort
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key_in[30:0], pad[31]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sorted_key[30:0], pad[31]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // overflowed
);

    dlrs_pkg::cmd_t                 cmd;
    dlrs_pkg::stat_t                stat;
    logic [dlrs_pkg::KEY_W-1:0]     out_key;

    dlrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dlrs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (s_axis_tdata[dlrs_pkg::KEY_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_key   (out_key),
        .out_last  (m_axis_tlast),
        .out_ovf   (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_key};

endmodule
